// ----- design/dsa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dsa_pkg;

    // map geometry
    localparam int MAP_PIXELS = 4096;
    localparam int SLOTS      = 9;
    localparam int SLOTS_2C   = 6;
    localparam int MAP_DEPTH  = MAP_PIXELS * SLOTS;
    localparam int MAP_AW     = $clog2(MAP_DEPTH);
    localparam int PIX_W      = 12;

    // weight tables
    localparam int WT_DEPTH   = 1024;
    localparam int WT_AW      = $clog2(WT_DEPTH);
    localparam int PHASE_W    = 10;
    localparam int PERIOD_W   = 11;
    localparam int PHASE_WRAP = 1024;

    // datapath widths
    localparam int DATA_W     = 32;
    localparam int GAIN_W     = 16;
    localparam int WT_W       = 16;
    localparam int MAP_W      = 48;
    localparam int P1_W       = 48;
    localparam int P2_W       = 64;
    localparam int TERM_W     = 50;
    localparam int SUM_W      = 51;
    localparam int SLOT_W     = 4;
    localparam int ENTRY_W    = 10;
    localparam int CFG_IW     = 3;
    localparam int CFG_DW     = 64;

    localparam logic signed [MAP_W-1:0] MAP_MAX = {1'b0, {(MAP_W-1){1'b1}}};
    localparam logic signed [MAP_W-1:0] MAP_MIN = {1'b1, {(MAP_W-1){1'b0}}};

    // reset values of the configuration registers
    localparam logic [CFG_DW-1:0]   GAIN4_RST  = 64'h4000_4000_4000_4000;
    localparam logic [GAIN_W-1:0]   GAIN8_RST  = 16'h4000;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 11'd1024;

    typedef enum logic [2:0] {
        CMD_LOAD_Q  = 3'd0,
        CMD_LOAD_U  = 3'd1,
        CMD_ACC     = 3'd2,
        CMD_READ    = 3'd3,
        CMD_WRITE   = 3'd4,
        CMD_RESTART = 3'd5
    } t_cmd;

    typedef enum logic [CFG_IW-1:0] {
        CFG_MODE    = 3'd0,
        CFG_GAIN_LO = 3'd1,
        CFG_GAIN_HI = 3'd2,
        CFG_GAIN_8  = 3'd3,
        CFG_Q_PER   = 3'd4,
        CFG_U_PER   = 3'd5
    } t_cfg_idx;

    // slot weighting kind
    typedef enum logic [1:0] {
        KIND_UNIT = 2'd0,
        KIND_Q    = 2'd1,
        KIND_U    = 2'd2
    } t_kind;

    typedef struct packed {
        logic                   three_comp;
        logic [CFG_DW-1:0]      gains_lo;
        logic [CFG_DW-1:0]      gains_hi;
        logic [GAIN_W-1:0]      gain_8;
        logic [PERIOD_W-1:0]    q_period;
        logic [PERIOD_W-1:0]    u_period;
    } t_cfg;

    // one word from front to back
    typedef struct packed {
        logic [2:0]             cmd;
        logic [PIX_W-1:0]       pixel;
        logic [SLOT_W-1:0]      slot;
        logic [DATA_W-1:0]      data;
        logic [WT_W-1:0]        qw;
        logic [WT_W-1:0]        uw;
    } t_work;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC_RD,
        ST_ACC_MUL,
        ST_ACC_ADD,
        ST_ACC_WR,
        ST_RD_DATA
    } t_back_state;

    localparam int QUEUE_DEPTH = 2;

    function automatic t_kind slot_kind(input logic three_comp, input logic [SLOT_W-1:0] k);
        t_kind r;
        if (three_comp) begin
            case (k)
                4'd0, 4'd3, 4'd6: r = KIND_UNIT;
                4'd1, 4'd4, 4'd7: r = KIND_Q;
                default:          r = KIND_U;
            endcase
        end else begin
            r = k[0] ? KIND_U : KIND_Q;
        end
        return r;
    endfunction

    function automatic logic [GAIN_W-1:0] slot_gain(input t_cfg c, input logic [SLOT_W-1:0] k);
        logic [GAIN_W-1:0] g;
        case (k)
            4'd0:    g = c.gains_lo[15:0];
            4'd1:    g = c.gains_lo[31:16];
            4'd2:    g = c.gains_lo[47:32];
            4'd3:    g = c.gains_lo[63:48];
            4'd4:    g = c.gains_hi[15:0];
            4'd5:    g = c.gains_hi[31:16];
            4'd6:    g = c.gains_hi[47:32];
            4'd7:    g = c.gains_hi[63:48];
            default: g = c.gain_8;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

// ----- design/depointing_scatter_accumulate.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Map binning unit: scatters time samples into a 4096 x 9 map of 48-bit
// accumulators, with load/read/write/restart commands on the same channel.
// Input channel: push/full, one command word per accepted push.
// Result channel: empty/pop, exactly one result word per command, in order.
// Configuration: cfg_we/cfg_idx/cfg_data, to be written by the user only while
// the block idles; the block itself does not enforce this. A command word is
// registered in the front stage (weight table read for accumulate), moves on
// into a two-word queue when the queue has room and is taken by the back end
// when it idles and its result register is free or being popped. The back end
// handles load, write, restart and unknown commands in its idle state, read in
// the idle and read-data states, and accumulate as a read, multiply, add and
// write step per map slot (nine slots in three-component mode, six in
// two-component mode). Simple commands stream at one word a cycle while results
// are popped; the back end takes no new word until an accumulate is done.
// Reset: a clearing pass zeroes the map, one element a cycle; full stays high
// until it ends. Phases reset to zero, tables are undefined. A stalled result
// receiver holds the result register; the back end then waits, the queue fills
// and full rises.
module depointing_scatter_accumulate (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_push,
    output logic                                     o_full,
    input  wire logic [2:0]                          i_command,
    input  wire logic [dsa_pkg::PIX_W-1:0]           i_pixel,
    input  wire logic [dsa_pkg::SLOT_W-1:0]          i_slot,
    input  wire logic [dsa_pkg::ENTRY_W-1:0]         i_table_entry,
    input  wire logic signed [dsa_pkg::DATA_W-1:0]   i_data_value,
    output logic                                     o_empty,
    input  wire logic                                i_pop,
    output logic signed [dsa_pkg::MAP_W-1:0]         o_read_value,
    output logic                                     o_saturated,
    input  wire logic                                i_cfg_we,
    input  wire logic [dsa_pkg::CFG_IW-1:0]          i_cfg_idx,
    input  wire logic [dsa_pkg::CFG_DW-1:0]          i_cfg_data
);

    dsa_pkg::t_cfg  r_cfg;
    dsa_pkg::t_work f_word, q_word;
    logic stage_free, f_push, q_full, q_valid, q_pop, clearing, accept;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.three_comp <= 1'b1;
            r_cfg.gains_lo   <= dsa_pkg::GAIN4_RST;
            r_cfg.gains_hi   <= dsa_pkg::GAIN4_RST;
            r_cfg.gain_8     <= dsa_pkg::GAIN8_RST;
            r_cfg.q_period   <= dsa_pkg::PERIOD_RST;
            r_cfg.u_period   <= dsa_pkg::PERIOD_RST;
        end else if (i_cfg_we) begin
            case (dsa_pkg::t_cfg_idx'(i_cfg_idx))
                dsa_pkg::CFG_MODE:    r_cfg.three_comp <= i_cfg_data[0];
                dsa_pkg::CFG_GAIN_LO: r_cfg.gains_lo   <= i_cfg_data;
                dsa_pkg::CFG_GAIN_HI: r_cfg.gains_hi   <= i_cfg_data;
                dsa_pkg::CFG_GAIN_8:  r_cfg.gain_8     <= i_cfg_data[dsa_pkg::GAIN_W-1:0];
                dsa_pkg::CFG_Q_PER:   r_cfg.q_period   <= i_cfg_data[dsa_pkg::PERIOD_W-1:0];
                dsa_pkg::CFG_U_PER:   r_cfg.u_period   <= i_cfg_data[dsa_pkg::PERIOD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_full = clearing || !stage_free;
        accept = i_push && !o_full;
    end

    dsa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_accept      (accept),
        .i_command     (i_command),
        .i_pixel       (i_pixel),
        .i_slot        (i_slot),
        .i_table_entry (i_table_entry),
        .i_data_value  (i_data_value),
        .o_stage_free  (stage_free),
        .o_push        (f_push),
        .o_word        (f_word),
        .i_q_full      (q_full)
    );

    dsa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_word  (f_word),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_word  (q_word)
    );

    dsa_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_valid    (q_valid),
        .i_word       (q_word),
        .o_q_pop      (q_pop),
        .o_clearing   (clearing),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_read_value (o_read_value),
        .o_saturated  (o_saturated)
    );

endmodule

`default_nettype wire

// ----- design/dsa_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dsa_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire dsa_pkg::t_cfg                 i_cfg,
    input  wire logic                          i_accept,
    input  wire logic [2:0]                    i_command,
    input  wire logic [dsa_pkg::PIX_W-1:0]     i_pixel,
    input  wire logic [dsa_pkg::SLOT_W-1:0]    i_slot,
    input  wire logic [dsa_pkg::ENTRY_W-1:0]   i_table_entry,
    input  wire logic [dsa_pkg::DATA_W-1:0]    i_data_value,
    output logic                               o_stage_free,
    output logic                               o_push,
    output dsa_pkg::t_work                     o_word,
    input  wire logic                          i_q_full
);

    logic [dsa_pkg::WT_W-1:0] r_q_tab [dsa_pkg::WT_DEPTH];
    logic [dsa_pkg::WT_W-1:0] r_u_tab [dsa_pkg::WT_DEPTH];
    logic [dsa_pkg::WT_W-1:0] r_qw, r_uw;
    logic [dsa_pkg::PHASE_W-1:0] r_q_phase, r_u_phase, n_q_phase, n_u_phase;
    logic r_sv;
    logic [2:0] r_cmd;
    logic [dsa_pkg::PIX_W-1:0] r_pixel;
    logic [dsa_pkg::SLOT_W-1:0] r_slot;
    logic [dsa_pkg::DATA_W-1:0] r_data;
    logic is_acc, is_ldq, is_ldu, is_rst, entry_ok;

    always_comb begin
        is_acc   = i_accept && (dsa_pkg::t_cmd'(i_command) == dsa_pkg::CMD_ACC);
        is_ldq   = i_accept && (dsa_pkg::t_cmd'(i_command) == dsa_pkg::CMD_LOAD_Q);
        is_ldu   = i_accept && (dsa_pkg::t_cmd'(i_command) == dsa_pkg::CMD_LOAD_U);
        is_rst   = i_accept && (dsa_pkg::t_cmd'(i_command) == dsa_pkg::CMD_RESTART);
        entry_ok = ({1'b0, i_table_entry} < (dsa_pkg::ENTRY_W+1)'(dsa_pkg::WT_DEPTH));
    end

    // phase step: wrap at period or at table span
    function automatic logic [dsa_pkg::PHASE_W-1:0] step_phase(
        input logic [dsa_pkg::PHASE_W-1:0] ph, input logic [dsa_pkg::PERIOD_W-1:0] per);
        logic [dsa_pkg::PERIOD_W-1:0] n;
        n = dsa_pkg::PERIOD_W'(ph) + 1'b1;
        if (n >= per || n >= dsa_pkg::PERIOD_W'(dsa_pkg::PHASE_WRAP)) begin
            return '0;
        end
        return n[dsa_pkg::PHASE_W-1:0];
    endfunction

    always_comb begin
        n_q_phase = r_q_phase;
        n_u_phase = r_u_phase;
        if (is_acc) begin
            n_q_phase = step_phase(r_q_phase, i_cfg.q_period);
            n_u_phase = step_phase(r_u_phase, i_cfg.u_period);
        end else if (is_rst) begin
            n_q_phase = '0;
            n_u_phase = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_phase <= '0;
            r_u_phase <= '0;
        end else begin
            r_q_phase <= n_q_phase;
            r_u_phase <= n_u_phase;
        end
    end

    // weight tables: load writes, accumulate reads at current phase
    always_ff @(posedge i_clk) begin
        if (is_ldq && entry_ok) begin
            r_q_tab[i_table_entry[dsa_pkg::WT_AW-1:0]] <= i_data_value[dsa_pkg::WT_W-1:0];
        end
        if (is_acc) begin
            r_qw <= r_q_tab[r_q_phase[dsa_pkg::WT_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_ldu && entry_ok) begin
            r_u_tab[i_table_entry[dsa_pkg::WT_AW-1:0]] <= i_data_value[dsa_pkg::WT_W-1:0];
        end
        if (is_acc) begin
            r_uw <= r_u_tab[r_u_phase[dsa_pkg::WT_AW-1:0]];
        end
    end

    // stage register holding one classified word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else if (i_accept) begin
            r_sv <= 1'b1;
        end else if (r_sv && !i_q_full) begin
            r_sv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_cmd   <= i_command;
            r_pixel <= i_pixel;
            r_slot  <= i_slot;
            r_data  <= i_data_value;
        end
    end

    always_comb begin
        o_stage_free = !r_sv || !i_q_full;
        o_push       = r_sv && !i_q_full;
        o_word.cmd   = r_cmd;
        o_word.pixel = r_pixel;
        o_word.slot  = r_slot;
        o_word.data  = r_data;
        o_word.qw    = r_qw;
        o_word.uw    = r_uw;
    end

    // phases only move on accumulate or restart
    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(is_acc) && !$past(is_rst) && $past(i_rst_n) |-> $stable(r_q_phase))
        else $error("phase moved without accumulate or restart");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |-> o_stage_free)
        else $error("accept while stage busy");
    a_push_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> r_sv)
        else $error("push without word");

endmodule

`default_nettype wire

// ----- design/dsa_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dsa_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire dsa_pkg::t_work i_word,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output dsa_pkg::t_work      o_word
);

    localparam int AW = $clog2(dsa_pkg::QUEUE_DEPTH);

    dsa_pkg::t_work r_ent [dsa_pkg::QUEUE_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    always_comb begin
        o_full  = (r_cnt == (AW+1)'(dsa_pkg::QUEUE_DEPTH));
        o_valid = (r_cnt != '0);
        o_word  = r_ent[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_word;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue underflow");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(dsa_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

// ----- design/dsa_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dsa_back (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire dsa_pkg::t_cfg                      i_cfg,
    input  wire logic                               i_q_valid,
    input  wire dsa_pkg::t_work                     i_word,
    output logic                                    o_q_pop,
    output logic                                    o_clearing,
    output logic                                    o_empty,
    input  wire logic                               i_pop,
    output logic signed [dsa_pkg::MAP_W-1:0]        o_read_value,
    output logic                                    o_saturated
);

    dsa_pkg::t_back_state r_state, n_state;

    logic [dsa_pkg::MAP_W-1:0]  r_map [dsa_pkg::MAP_DEPTH];
    logic signed [dsa_pkg::MAP_W-1:0] r_rdata;
    logic [dsa_pkg::MAP_AW-1:0] r_clr_cnt;
    logic                       r_clr;

    dsa_pkg::t_work             r_w;
    logic [dsa_pkg::MAP_AW-1:0] r_base;
    logic [dsa_pkg::SLOT_W-1:0] r_k;
    logic signed [dsa_pkg::P1_W-1:0]   r_p1;
    logic signed [dsa_pkg::P2_W-1:0]   r_p2;
    logic signed [dsa_pkg::TERM_W-1:0] r_term;
    logic                       r_unit;
    logic                       r_sat;
    logic                       r_ov;
    logic signed [dsa_pkg::MAP_W-1:0] r_oval;
    logic                       r_osat;

    // combinational controls
    logic take, pix_ok, slot_ok, last_slot;
    logic mem_we, mem_re;
    logic [dsa_pkg::MAP_AW-1:0] mem_wa, mem_ra, head_base;
    logic [dsa_pkg::MAP_W-1:0]  mem_wd;
    logic signed [dsa_pkg::SUM_W-1:0] sum;
    logic signed [dsa_pkg::MAP_W-1:0] sum_sat;
    logic sum_clip;
    dsa_pkg::t_kind kind;
    logic [dsa_pkg::WT_W-1:0] wsel;
    logic signed [dsa_pkg::GAIN_W-1:0] gain;
    logic out_load;
    logic signed [dsa_pkg::MAP_W-1:0] out_val;
    logic out_sat;

    always_comb begin
        take = (r_state == dsa_pkg::ST_IDLE) && !r_clr && i_q_valid && (!r_ov || i_pop);
        head_base = dsa_pkg::MAP_AW'(i_word.pixel) * dsa_pkg::MAP_AW'(dsa_pkg::SLOTS);
        pix_ok  = ({1'b0, i_word.pixel} < (dsa_pkg::PIX_W+1)'(dsa_pkg::MAP_PIXELS));
        slot_ok = (i_word.slot < dsa_pkg::SLOT_W'(dsa_pkg::SLOTS));
        kind  = dsa_pkg::slot_kind(i_cfg.three_comp, r_k);
        gain  = dsa_pkg::slot_gain(i_cfg, r_k);
        wsel  = (kind == dsa_pkg::KIND_U) ? r_w.uw : r_w.qw;
        last_slot = i_cfg.three_comp ? (r_k == dsa_pkg::SLOT_W'(dsa_pkg::SLOTS - 1))
                                     : (r_k == dsa_pkg::SLOT_W'(dsa_pkg::SLOTS_2C - 1));
        sum = dsa_pkg::SUM_W'(r_rdata) + dsa_pkg::SUM_W'(r_term);
        sum_clip = 1'b0;
        sum_sat  = dsa_pkg::MAP_W'(sum);
        if (sum > dsa_pkg::SUM_W'(dsa_pkg::MAP_MAX)) begin
            sum_sat  = dsa_pkg::MAP_MAX;
            sum_clip = 1'b1;
        end else if (sum < dsa_pkg::SUM_W'(dsa_pkg::MAP_MIN)) begin
            sum_sat  = dsa_pkg::MAP_MIN;
            sum_clip = 1'b1;
        end
    end

    // next state, memory port and result load
    always_comb begin
        n_state  = r_state;
        mem_we   = 1'b0;
        mem_wa   = r_base + dsa_pkg::MAP_AW'(r_k);
        mem_wd   = sum_sat;
        mem_re   = 1'b0;
        mem_ra   = r_base + dsa_pkg::MAP_AW'(r_k);
        out_load = 1'b0;
        out_val  = '0;
        out_sat  = 1'b0;
        o_q_pop  = take;
        if (r_clr) begin
            mem_we = 1'b1;
            mem_wa = r_clr_cnt;
            mem_wd = '0;
        end
        case (r_state)
            dsa_pkg::ST_IDLE: begin
                if (take) begin
                    case (dsa_pkg::t_cmd'(i_word.cmd))
                        dsa_pkg::CMD_ACC: begin
                            if (pix_ok) begin
                                n_state = dsa_pkg::ST_ACC_RD;
                            end else begin
                                out_load = 1'b1;
                            end
                        end
                        dsa_pkg::CMD_READ: begin
                            if (pix_ok && slot_ok) begin
                                mem_re  = 1'b1;
                                mem_ra  = head_base + dsa_pkg::MAP_AW'(i_word.slot);
                                n_state = dsa_pkg::ST_RD_DATA;
                            end else begin
                                out_load = 1'b1;
                            end
                        end
                        dsa_pkg::CMD_WRITE: begin
                            out_load = 1'b1;
                            if (pix_ok && slot_ok) begin
                                mem_we = 1'b1;
                                mem_wa = head_base + dsa_pkg::MAP_AW'(i_word.slot);
                                mem_wd = {{2{i_word.data[dsa_pkg::DATA_W-1]}},
                                          i_word.data, 14'b0};
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            dsa_pkg::ST_ACC_RD: begin
                mem_re  = 1'b1;
                n_state = dsa_pkg::ST_ACC_MUL;
            end
            dsa_pkg::ST_ACC_MUL: begin
                n_state = dsa_pkg::ST_ACC_ADD;
            end
            dsa_pkg::ST_ACC_ADD: begin
                n_state = dsa_pkg::ST_ACC_WR;
            end
            dsa_pkg::ST_ACC_WR: begin
                mem_we = 1'b1;
                if (last_slot) begin
                    out_load = 1'b1;
                    out_sat  = r_sat || sum_clip;
                    n_state  = dsa_pkg::ST_IDLE;
                end else begin
                    n_state = dsa_pkg::ST_ACC_RD;
                end
            end
            dsa_pkg::ST_RD_DATA: begin
                out_load = 1'b1;
                out_val  = r_rdata;
                n_state  = dsa_pkg::ST_IDLE;
            end
            default: begin
                n_state = dsa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dsa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_cnt <= '0;
        end else if (r_clr) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == dsa_pkg::MAP_AW'(dsa_pkg::MAP_DEPTH - 1)) begin
                r_clr <= 1'b0;
            end
        end
    end

    // map memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_map[mem_ra];
        end
    end

    // accumulate datapath
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_w    <= i_word;
            r_base <= head_base;
            r_k    <= '0;
            r_sat  <= 1'b0;
        end
        case (r_state)
            dsa_pkg::ST_ACC_RD: begin
                r_p1   <= dsa_pkg::P1_W'(gain) * dsa_pkg::P1_W'(signed'(r_w.data));
                r_unit <= (kind == dsa_pkg::KIND_UNIT);
            end
            dsa_pkg::ST_ACC_MUL: begin
                r_p2 <= dsa_pkg::P2_W'(r_p1) * dsa_pkg::P2_W'(signed'(wsel));
            end
            dsa_pkg::ST_ACC_ADD: begin
                r_term <= r_unit ? dsa_pkg::TERM_W'(r_p1)
                                 : dsa_pkg::TERM_W'((r_p2 + dsa_pkg::P2_W'(8192)) >>> 14);
            end
            dsa_pkg::ST_ACC_WR: begin
                r_sat <= r_sat || sum_clip;
                r_k   <= r_k + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (i_pop) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_oval <= out_val;
            r_osat <= out_sat;
        end
    end

    always_comb begin
        o_clearing   = r_clr;
        o_empty      = !r_ov;
        o_read_value = r_oval;
        o_saturated  = r_osat;
    end

    a_no_work_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> r_state == dsa_pkg::ST_IDLE)
        else $error("work during clearing pass");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> !r_ov || i_pop)
        else $error("result overwritten");
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == dsa_pkg::ST_ACC_WR |-> r_k < dsa_pkg::SLOT_W'(dsa_pkg::SLOTS))
        else $error("slot counter out of range");

endmodule

`default_nettype wire
